// File: hdl/ssa_pkg.sv
// Shared types, constants and helper functions of the slab slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

    localparam int NUM_CHUNKS      = 16;
    localparam int CHUNK_W         = 4;
    localparam int LINK_W          = 5;
    localparam int MAX_SLOTS       = 256;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_CHUNK = 4;
    localparam int WSEL_W          = 2;
    localparam int BIT_W           = 6;
    localparam int BM_DEPTH        = NUM_CHUNKS * WORDS_PER_CHUNK;
    localparam int SLOT_W          = 8;
    localparam int CNT_W           = 9;
    localparam int UNITS_W         = 13;
    localparam int SCNT_W          = 5;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 13;

    localparam logic [LINK_W-1:0] NIL_CODE = LINK_W'(NUM_CHUNKS);

    localparam logic [CFG_ADDR_W-1:0] CFG_SLOTS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef enum logic [1:0] {TAG_NONE, TAG_PARTIAL, TAG_EMPTY} t_tag;
    typedef enum logic [1:0] {LOP_NONE, LOP_PUSH, LOP_REMOVE} t_list_op;
    typedef enum logic {LST_PARTIAL, LST_EMPTY} t_list_sel;

    typedef struct packed {
        t_list_op           op;
        t_list_sel          sel;
        logic [CHUNK_W-1:0] chunk;
    } t_list_cmd;

    typedef struct packed {
        logic [LINK_W-1:0] phead;
        logic [LINK_W-1:0] ehead;
        t_tag              tag;
    } t_list_stat;

    typedef struct packed {
        logic [1:0]         status;
        logic [CHUNK_W-1:0] gchunk;
        logic [SLOT_W-1:0]  gslot;
        logic [UNITS_W-1:0] units;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE, S_SPARE_POP, S_SPARE_FILL, S_SPARE_PUSH, S_PROMOTE, S_PROMOTE_PUSH,
        S_SCAN_START, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_FIN, S_FREE_RD, S_FREE_CHK,
        S_FREE_PUSH, S_FREE_MOVE, S_FREE_PUSH_E, S_TRIM, S_RESP
    } t_state;

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    // Initial free bitmap word of a fresh chunk with s slots.
    function automatic logic [WORD_BITS-1:0] fill_word(input logic [CNT_W-1:0] s,
                                                      input logic [WSEL_W-1:0] w);
        logic [CNT_W-1:0]     base;
        logic [CNT_W-1:0]     rem;
        logic [WORD_BITS-1:0] v;
        base = {1'b0, w, 6'd0};
        rem  = s - base;
        if (s >= base + CNT_W'(WORD_BITS)) v = '1;
        else if (s > base) v = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
        else v = '0;
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ssa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/ssa_lists.sv
// Partly-free and empty chunk lists: links, heads and per-chunk list tag.
`timescale 1ns / 1ps
`default_nettype none
module ssa_lists
    import ssa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_list_cmd          i_cmd,
    input  wire logic [CHUNK_W-1:0] i_query,
    output t_list_stat              o_stat
);
    logic [LINK_W-1:0] r_next [NUM_CHUNKS];
    logic [LINK_W-1:0] r_prev [NUM_CHUNKS];
    t_tag              r_tag  [NUM_CHUNKS];
    logic [LINK_W-1:0] r_phead, r_ehead;
    logic [LINK_W-1:0] n_next [NUM_CHUNKS];
    logic [LINK_W-1:0] n_prev [NUM_CHUNKS];
    t_tag              n_tag  [NUM_CHUNKS];
    logic [LINK_W-1:0] n_phead, n_ehead;

    always_comb begin
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        n_next  = r_next;
        n_prev  = r_prev;
        n_tag   = r_tag;
        n_phead = r_phead;
        n_ehead = r_ehead;
        head    = (i_cmd.sel == LST_PARTIAL) ? r_phead : r_ehead;
        p       = r_prev[i_cmd.chunk];
        n       = r_next[i_cmd.chunk];
        unique case (i_cmd.op)
            LOP_PUSH: begin
                n_prev[i_cmd.chunk] = NIL_CODE;
                n_next[i_cmd.chunk] = head;
                if (!head[LINK_W-1]) n_prev[head[CHUNK_W-1:0]] = {1'b0, i_cmd.chunk};
                if (i_cmd.sel == LST_PARTIAL) begin
                    n_phead = {1'b0, i_cmd.chunk};
                    n_tag[i_cmd.chunk] = TAG_PARTIAL;
                end else begin
                    n_ehead = {1'b0, i_cmd.chunk};
                    n_tag[i_cmd.chunk] = TAG_EMPTY;
                end
            end
            LOP_REMOVE: begin
                if (!p[LINK_W-1]) n_next[p[CHUNK_W-1:0]] = n;
                else if (i_cmd.sel == LST_PARTIAL) n_phead = n;
                else n_ehead = n;
                if (!n[LINK_W-1]) n_prev[n[CHUNK_W-1:0]] = p;
                n_tag[i_cmd.chunk] = TAG_NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phead <= NIL_CODE;
            r_ehead <= NIL_CODE;
            for (int i = 0; i < NUM_CHUNKS; i++) r_tag[i] <= TAG_NONE;
        end else begin
            r_phead <= n_phead;
            r_ehead <= n_ehead;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_prev <= n_prev;
    end

    assign o_stat.phead = r_phead;
    assign o_stat.ehead = r_ehead;
    assign o_stat.tag   = r_tag[i_query];
endmodule
`default_nettype wire

// File: hdl/ssa_ctrl.sv
// Request sequencer: bitmap read-modify-write, free counts, spare stack and unit total.
`timescale 1ns / 1ps
`default_nettype none
module ssa_ctrl
    import ssa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [CHUNK_W-1:0]    i_chunk_id,
    input  wire logic [SLOT_W-1:0]     i_slot_index,
    input  wire logic [CNT_W-1:0]      i_slots_cfg,
    input  wire logic [UNITS_W-1:0]    i_min_units,
    input  wire logic [UNITS_W-1:0]    i_max_units,
    input  wire logic                  i_out_free,
    output logic                       o_done,
    output t_result                    o_result
);
    localparam int BM_AW = $clog2(BM_DEPTH);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count [NUM_CHUNKS];
    logic [CNT_W-1:0]     n_count [NUM_CHUNKS];
    logic                 r_owned [NUM_CHUNKS];
    logic                 n_owned [NUM_CHUNKS];
    logic [CHUNK_W-1:0]   r_stack [NUM_CHUNKS];
    logic [CHUNK_W-1:0]   n_stack [NUM_CHUNKS];
    logic [SCNT_W-1:0]    r_scnt, n_scnt;
    logic [UNITS_W-1:0]   r_avail, n_avail;
    logic                 r_ret_resp, n_ret_resp;
    logic [CHUNK_W-1:0]   r_chunk, n_chunk;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [WSEL_W-1:0]    r_word, n_word;
    logic [1:0]           r_status, n_status;
    logic [CHUNK_W-1:0]   r_gchunk, n_gchunk;
    logic [SLOT_W-1:0]    r_gslot, n_gslot;

    logic [CNT_W-1:0]     eff;
    t_list_cmd            lcmd;
    t_list_stat           lst;
    logic                 ram_we;
    logic [BM_AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    // Clamp the slot count into its legal range.
    always_comb begin
        if (i_slots_cfg < CNT_W'(2)) eff = CNT_W'(2);
        else if (i_slots_cfg > CNT_W'(MAX_SLOTS)) eff = CNT_W'(MAX_SLOTS);
        else eff = i_slots_cfg;
    end

    ssa_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ssa_lists u_lists (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lcmd),
        .i_query (r_chunk),
        .o_stat  (lst)
    );

    always_comb begin
        logic [SCNT_W-1:0]  sc_m1;
        logic [CHUNK_W-1:0] c;
        logic [BIT_W-1:0]   b;
        n_state    = r_state;
        n_count    = r_count;
        n_owned    = r_owned;
        n_stack    = r_stack;
        n_scnt     = r_scnt;
        n_avail    = r_avail;
        n_ret_resp = r_ret_resp;
        n_chunk    = r_chunk;
        n_slot     = r_slot;
        n_word     = r_word;
        n_status   = r_status;
        n_gchunk   = r_gchunk;
        n_gslot    = r_gslot;
        lcmd.op    = LOP_NONE;
        lcmd.sel   = LST_PARTIAL;
        lcmd.chunk = r_chunk;
        ram_we     = 1'b0;
        ram_waddr  = {r_chunk, r_word};
        ram_wdata  = ram_rdata;
        ram_raddr  = {r_chunk, r_word};
        o_done     = 1'b0;
        sc_m1      = r_scnt - SCNT_W'(1);
        c          = lst.ehead[CHUNK_W-1:0];
        b          = lowest_bit(ram_rdata);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_gchunk = '0;
                    n_gslot  = '0;
                    n_chunk  = i_chunk_id;
                    n_slot   = i_slot_index;
                    if (!i_req_type) begin
                        n_ret_resp = 1'b0;
                        n_state    = (r_avail <= i_min_units) ? S_SPARE_POP : S_PROMOTE;
                    end else if (!r_owned[i_chunk_id] || {1'b0, i_slot_index} >= eff) begin
                        n_status = ST_BAD_FREE;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_SPARE_POP: begin
                if (r_scnt == '0) begin
                    n_state = r_ret_resp ? S_RESP : S_PROMOTE;
                end else begin
                    n_scnt  = sc_m1;
                    n_chunk = r_stack[sc_m1[CHUNK_W-1:0]];
                    n_count[r_stack[sc_m1[CHUNK_W-1:0]]] = eff;
                    n_owned[r_stack[sc_m1[CHUNK_W-1:0]]] = 1'b1;
                    n_avail = r_avail + UNITS_W'(eff);
                    n_word  = '0;
                    n_state = S_SPARE_FILL;
                end
            end
            S_SPARE_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = fill_word(eff, r_word);
                n_word    = r_word + WSEL_W'(1);
                if (r_word == WSEL_W'(WORDS_PER_CHUNK - 1)) n_state = S_SPARE_PUSH;
            end
            S_SPARE_PUSH: begin
                lcmd.op  = LOP_PUSH;
                lcmd.sel = LST_EMPTY;
                n_state  = r_ret_resp ? S_RESP : S_PROMOTE;
            end
            S_PROMOTE: begin
                if (lst.phead[LINK_W-1] && !lst.ehead[LINK_W-1]) begin
                    lcmd.op    = LOP_REMOVE;
                    lcmd.sel   = LST_EMPTY;
                    lcmd.chunk = c;
                    n_chunk    = c;
                    n_state    = S_PROMOTE_PUSH;
                end else begin
                    n_state = S_SCAN_START;
                end
            end
            S_PROMOTE_PUSH: begin
                lcmd.op  = LOP_PUSH;
                lcmd.sel = LST_PARTIAL;
                n_state  = S_SCAN_START;
            end
            S_SCAN_START: begin
                if (lst.phead[LINK_W-1]) begin
                    n_status = ST_OOM;
                    n_state  = S_RESP;
                end else begin
                    n_chunk = lst.phead[CHUNK_W-1:0];
                    n_word  = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (ram_rdata != '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(WORD_BITS'(1) << b);
                    n_gchunk  = r_chunk;
                    n_gslot   = {r_word, b};
                    n_state   = S_ALLOC_FIN;
                end else if (r_word == WSEL_W'(WORDS_PER_CHUNK - 1)) begin
                    n_status = ST_OOM;
                    n_state  = S_RESP;
                end else begin
                    n_word  = r_word + WSEL_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_ALLOC_FIN: begin
                if (r_count[r_chunk] == '0) begin
                    n_status = ST_OOM;
                    n_gchunk = '0;
                    n_gslot  = '0;
                end else begin
                    n_count[r_chunk] = r_count[r_chunk] - CNT_W'(1);
                    if (r_avail != '0) n_avail = r_avail - UNITS_W'(1);
                    if (r_count[r_chunk] == CNT_W'(1)) begin
                        lcmd.op  = LOP_REMOVE;
                        lcmd.sel = LST_PARTIAL;
                    end
                end
                n_state = S_RESP;
            end
            S_FREE_RD: begin
                ram_raddr = {r_chunk, r_slot[SLOT_W-1 -: WSEL_W]};
                n_state   = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (ram_rdata[r_slot[BIT_W-1:0]]) begin
                    n_status = ST_BAD_FREE;
                    n_state  = S_RESP;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_chunk, r_slot[SLOT_W-1 -: WSEL_W]};
                    ram_wdata = ram_rdata | (WORD_BITS'(1) << r_slot[BIT_W-1:0]);
                    n_count[r_chunk] = r_count[r_chunk] + CNT_W'(1);
                    n_avail = r_avail + UNITS_W'(1);
                    n_state = (lst.tag == TAG_NONE) ? S_FREE_PUSH : S_FREE_MOVE;
                end
            end
            S_FREE_PUSH: begin
                lcmd.op  = LOP_PUSH;
                lcmd.sel = LST_PARTIAL;
                n_state  = S_FREE_MOVE;
            end
            S_FREE_MOVE: begin
                if (r_count[r_chunk] >= eff && lst.tag == TAG_PARTIAL) begin
                    lcmd.op  = LOP_REMOVE;
                    lcmd.sel = LST_PARTIAL;
                    n_state  = S_FREE_PUSH_E;
                end else begin
                    n_state = S_TRIM;
                end
            end
            S_FREE_PUSH_E: begin
                lcmd.op  = LOP_PUSH;
                lcmd.sel = LST_EMPTY;
                n_state  = S_TRIM;
            end
            S_TRIM: begin
                // Release one empty chunk a cycle while units exceed the maximum.
                if (!lst.ehead[LINK_W-1] && r_avail > i_max_units) begin
                    lcmd.op    = LOP_REMOVE;
                    lcmd.sel   = LST_EMPTY;
                    lcmd.chunk = c;
                    if (UNITS_W'(r_count[c]) <= r_avail) n_avail = r_avail - UNITS_W'(r_count[c]);
                    else n_avail = '0;
                    n_count[c] = '0;
                    n_owned[c] = 1'b0;
                    if (!r_scnt[SCNT_W-1]) begin
                        n_stack[r_scnt[CHUNK_W-1:0]] = c;
                        n_scnt = r_scnt + SCNT_W'(1);
                    end
                end else if (r_avail <= i_min_units) begin
                    n_ret_resp = 1'b1;
                    n_state    = S_SPARE_POP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_done = 1'b1;
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scnt  <= SCNT_W'(NUM_CHUNKS);
            r_avail <= '0;
            for (int i = 0; i < NUM_CHUNKS; i++) begin
                r_count[i] <= '0;
                r_owned[i] <= 1'b0;
                r_stack[i] <= CHUNK_W'(NUM_CHUNKS - 1 - i);
            end
        end else begin
            r_state <= n_state;
            r_scnt  <= n_scnt;
            r_avail <= n_avail;
            r_count <= n_count;
            r_owned <= n_owned;
            r_stack <= n_stack;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_resp <= n_ret_resp;
        r_chunk    <= n_chunk;
        r_slot     <= n_slot;
        r_word     <= n_word;
        r_status   <= n_status;
        r_gchunk   <= n_gchunk;
        r_gslot    <= n_gslot;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_result.status = r_status;
    assign o_result.gchunk = r_gchunk;
    assign o_result.gslot  = r_gslot;
    assign o_result.units  = r_avail;
endmodule
`default_nettype wire

// File: hdl/slab_slot_allocator_top.sv
// Slab slot allocator top level: stream ports, configuration registers, output register.
// One request at a time. Allocate: pull a spare chunk if needed (four bitmap word writes),
// promote an empty chunk, scan up to 4 bitmap words. Free: rejected on entry or as a double
// free, else the slot is set free, empty chunks are released while units exceed the maximum
// and a spare may be pulled. Result lands in an output register; the next beat is taken while
// it waits. Reset is synchronous, active low; bitmap words and links are written before use.
`timescale 1ns / 1ps
`default_nettype none
module slab_slot_allocator_top
    import ssa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // chunk_id[3:0], slot_index[11:4], zero pad
    input  wire logic                  s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [31:0]           m_axis_tdata,  // given_chunk[3:0], given_slot[11:4],
                                                      // units_left[24:12], zero pad
    output logic      [1:0]            m_axis_tuser,  // status
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);
    logic [CNT_W-1:0]   r_slots;
    logic [UNITS_W-1:0] r_min, r_max;
    logic               r_mvalid;
    t_result            r_res;
    logic               out_free;
    logic               done;
    t_result            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= CNT_W'(MAX_SLOTS);
            r_min   <= '0;
            r_max   <= UNITS_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SLOTS: r_slots <= i_cfg_wdata[CNT_W-1:0];
                CFG_MIN:   r_min   <= i_cfg_wdata[UNITS_W-1:0];
                CFG_MAX:   r_max   <= i_cfg_wdata[UNITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_mvalid || m_axis_tready;

    ssa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_chunk_id   (s_axis_tdata[3:0]),
        .i_slot_index (s_axis_tdata[11:4]),
        .i_slots_cfg  (r_slots),
        .i_min_units  (r_min),
        .i_max_units  (r_max),
        .i_out_free   (out_free),
        .o_done       (done),
        .o_result     (res)
    );

    // Hold the result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (out_free) begin
            r_mvalid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && done) r_res <= res;
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {7'd0, r_res.units, r_res.gslot, r_res.gchunk};
endmodule
`default_nettype wire

// File: tb/slab_slot_allocator_top_test.sv
// Self-checking testbench of the slab slot allocator: stream stimulus, allocator model, scoreboard.
`timescale 1ns / 1ps
module slab_slot_allocator_top_test;
    import ssa_pkg::*;

    localparam int RUN_LIMIT = 400000;

    typedef struct {
        logic [CHUNK_W-1:0] chunk;
        logic [SLOT_W-1:0]  slot;
    } t_handle;

    class slab_scoreboard;
        logic [WORD_BITS-1:0] free_bits [BM_DEPTH];
        logic [CNT_W-1:0]     free_cnt  [NUM_CHUNKS];
        bit                   owned     [NUM_CHUNKS];
        t_tag                 tag       [NUM_CHUNKS];
        logic [LINK_W-1:0]    nxt       [NUM_CHUNKS];
        logic [LINK_W-1:0]    prv       [NUM_CHUNKS];
        logic [LINK_W-1:0]    head      [2];
        logic [CHUNK_W-1:0]   spares    [NUM_CHUNKS];
        int                   spare_cnt;
        int                   avail;
        int                   cfg_slots, cfg_min, cfg_max;
        t_result              pending[$];
        int                   fails;

        function new();
            for (int i = 0; i < NUM_CHUNKS; i++) begin
                free_cnt[i] = '0;
                owned[i]    = 0;
                tag[i]      = TAG_NONE;
                spares[i]   = CHUNK_W'(NUM_CHUNKS - 1 - i);
            end
            head[LST_PARTIAL] = NIL_CODE;
            head[LST_EMPTY]   = NIL_CODE;
            spare_cnt = NUM_CHUNKS;
            avail     = 0;
            cfg_slots = 256;
            cfg_min   = 0;
            cfg_max   = 512;
            fails     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SLOTS: cfg_slots = int'(val[8:0]);
                CFG_MIN:   cfg_min   = int'(val);
                CFG_MAX:   cfg_max   = int'(val);
                default: ;
            endcase
        endfunction

        function int slot_count();
            if (cfg_slots < 2) return 2;
            if (cfg_slots > MAX_SLOTS) return MAX_SLOTS;
            return cfg_slots;
        endfunction

        function void link_in(int sel, int c, t_tag t);
            prv[c] = NIL_CODE;
            nxt[c] = head[sel];
            if (head[sel] != NIL_CODE) prv[head[sel]] = LINK_W'(c);
            head[sel] = LINK_W'(c);
            tag[c] = t;
        endfunction

        function void unlink(int sel, int c);
            logic [LINK_W-1:0] p, n;
            p = prv[c];
            n = nxt[c];
            if (p != NIL_CODE) nxt[p] = n; else head[sel] = n;
            if (n != NIL_CODE) prv[n] = p;
            tag[c] = TAG_NONE;
        endfunction

        function void pull_spare();
            int c, s, base;
            s = slot_count();
            if (spare_cnt == 0) return;
            spare_cnt--;
            c = spares[spare_cnt];
            for (int w = 0; w < WORDS_PER_CHUNK; w++) begin
                base = w * WORD_BITS;
                if (s >= base + WORD_BITS) free_bits[c*WORDS_PER_CHUNK+w] = '1;
                else if (s > base) free_bits[c*WORDS_PER_CHUNK+w] = (64'd1 << (s - base)) - 64'd1;
                else free_bits[c*WORDS_PER_CHUNK+w] = '0;
            end
            free_cnt[c] = CNT_W'(s);
            owned[c] = 1;
            avail += s;
            link_in(LST_EMPTY, c, TAG_EMPTY);
        endfunction

        function void release_empties();
            int c;
            while (head[LST_EMPTY] != NIL_CODE && avail > cfg_max) begin
                c = head[LST_EMPTY];
                unlink(LST_EMPTY, c);
                if (free_cnt[c] <= avail) avail -= free_cnt[c]; else avail = 0;
                free_cnt[c] = '0;
                owned[c] = 0;
                if (spare_cnt < NUM_CHUNKS) spares[spare_cnt++] = CHUNK_W'(c);
            end
        endfunction

        // Work out the answer to one accepted request and queue it.
        function t_result note_request(bit is_free, logic [CHUNK_W-1:0] ch,
                                       logic [SLOT_W-1:0] sl);
            t_result r;
            int c, wi;
            bit found;
            r = '0;
            found = 0;
            if (!is_free) begin
                if (avail <= cfg_min) pull_spare();
                if (head[LST_PARTIAL] == NIL_CODE && head[LST_EMPTY] != NIL_CODE) begin
                    c = head[LST_EMPTY];
                    unlink(LST_EMPTY, c);
                    link_in(LST_PARTIAL, c, TAG_PARTIAL);
                end
                if (head[LST_PARTIAL] == NIL_CODE) begin
                    r.status = ST_OOM;
                end else begin
                    c = head[LST_PARTIAL];
                    for (int w = 0; w < WORDS_PER_CHUNK && !found; w++) begin
                        wi = c * WORDS_PER_CHUNK + w;
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (free_bits[wi][b]) begin
                                free_bits[wi][b] = 1'b0;
                                r.gchunk = CHUNK_W'(c);
                                r.gslot  = SLOT_W'(w * WORD_BITS + b);
                                found = 1;
                            end
                        end
                    end
                    if (!found || free_cnt[c] == 0) begin
                        r.status = ST_OOM;
                        r.gchunk = '0;
                        r.gslot  = '0;
                    end else begin
                        free_cnt[c]--;
                        if (avail > 0) avail--;
                        if (free_cnt[c] == 0) unlink(LST_PARTIAL, c);
                    end
                end
            end else begin
                c = ch;
                wi = c * WORDS_PER_CHUNK + sl / WORD_BITS;
                if (!owned[c] || sl >= slot_count() || free_bits[wi][sl % WORD_BITS]) begin
                    r.status = ST_BAD_FREE;
                end else begin
                    free_bits[wi][sl % WORD_BITS] = 1'b1;
                    free_cnt[c]++;
                    avail++;
                    if (tag[c] == TAG_NONE) link_in(LST_PARTIAL, c, TAG_PARTIAL);
                    if (free_cnt[c] >= slot_count() && tag[c] == TAG_PARTIAL) begin
                        unlink(LST_PARTIAL, c);
                        link_in(LST_EMPTY, c, TAG_EMPTY);
                    end
                    release_empties();
                    if (avail <= cfg_min) pull_spare();
                end
            end
            r.units = UNITS_W'(avail);
            pending.push_back(r);
            return r;
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, got);
                fails++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                fails++;
            end
            if (got.gchunk !== exp.gchunk) begin
                $display("%0t: given_chunk expected %0d actual %0d", $time, exp.gchunk, got.gchunk);
                fails++;
            end
            if (got.gslot !== exp.gslot) begin
                $display("%0t: given_slot expected %0d actual %0d", $time, exp.gslot, got.gslot);
                fails++;
            end
            if (got.units !== exp.units) begin
                $display("%0t: units_left expected %0d actual %0d", $time, exp.units, got.units);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    slab_slot_allocator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    slab_scoreboard sb = new();
    t_handle        live[$];
    bit             quiet = 0;
    int             stall_left = 0;
    int             cycles = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("slab_slot_allocator_top_test NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Sample at the falling edge so the accepting rising edge follows.
    always @(negedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.gchunk = m_axis_tdata[3:0];
            got.gslot  = m_axis_tdata[11:4];
            got.units  = m_axis_tdata[24:12];
            sb.check_result(got);
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Present one beat, wait for its acceptance, then maybe leave a gap.
    task automatic send_req(bit is_free, logic [CHUNK_W-1:0] ch, logic [SLOT_W-1:0] sl);
        t_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_free;
        s_axis_tdata  <= {4'd0, sl, ch};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        r = sb.note_request(is_free, ch, sl);
        if (!is_free && r.status == ST_OK) live.push_back('{r.gchunk, r.gslot});
        if (is_free && r.status == ST_OK) begin
            for (int i = 0; i < live.size(); i++) begin
                if (live[i].chunk == ch && live[i].slot == sl) begin
                    live.delete(i);
                    break;
                end
            end
        end
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Random mix: mostly frees of live objects and allocates, some stray frees.
    task automatic random_phase(int n, int alloc_pct);
        int pick, k;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct || (live.size() == 0 && pick < 90)) begin
                send_req(1'b0, CHUNK_W'($urandom), SLOT_W'($urandom));
            end else if (pick < 90 && live.size() != 0) begin
                k = $urandom_range(0, live.size() - 1);
                send_req(1'b1, live[k].chunk, live[k].slot);
            end else begin
                send_req(1'b1, CHUNK_W'($urandom), SLOT_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first pull, frees of unowned chunks, double free, wholly free chunk.
        send_req(1'b1, 4'd15, 8'd255);
        send_req(1'b0, 4'd0, 8'd0);
        send_req(1'b0, 4'd15, 8'd255);
        send_req(1'b1, 4'd0, 8'd0);
        send_req(1'b1, 4'd0, 8'd0);
        send_req(1'b1, 4'd5, 8'd3);
        send_req(1'b1, 4'd0, 8'd1);
        send_req(1'b0, 4'd0, 8'd0);
        drain();

        // Tiny chunks, no headroom: exhaust the spare stack, slot out of range.
        write_reg(CFG_SLOTS, 13'd0);
        write_reg(CFG_MAX, 13'd0);
        for (int i = 0; i < 20; i++) send_req(1'b0, 4'd0, 8'd0);
        send_req(1'b1, 4'd0, 8'd2);
        random_phase(140, 75);
        drain();

        // Full-size chunks with both thresholds at 4096.
        write_reg(CFG_SLOTS, 13'd256);
        write_reg(CFG_MIN, 13'd4096);
        write_reg(CFG_MAX, 13'd4096);
        random_phase(150, 55);
        drain();

        // Slot register above range, saturating thresholds.
        write_reg(CFG_SLOTS, 13'd511);
        write_reg(CFG_MIN, 13'd8191);
        write_reg(CFG_MAX, 13'd8191);
        random_phase(60, 55);
        drain();

        write_reg(CFG_SLOTS, 13'd17);
        write_reg(CFG_MIN, 13'd5);
        write_reg(CFG_MAX, 13'd40);
        random_phase(200, 50);
        drain();

        write_reg(CFG_SLOTS, 13'd2);
        write_reg(CFG_MIN, 13'd0);
        write_reg(CFG_MAX, 13'd3);
        random_phase(150, 50);
        drain();

        // Closing stretch runs at full rate both sides.
        write_reg(CFG_SLOTS, 13'd100);
        write_reg(CFG_MIN, 13'd1);
        write_reg(CFG_MAX, 13'd300);
        quiet = 1;
        random_phase(170, 55);
        drain();

        if (sb.fails == 0) begin
            $display("slab_slot_allocator_top_test OK");
        end else begin
            $display("slab_slot_allocator_top_test NOT OK");
        end
        $finish;
    end

endmodule

// File: slab_slot_allocator_top.f
hdl/ssa_pkg.sv
hdl/ssa_ram.sv
hdl/ssa_lists.sv
hdl/ssa_ctrl.sv
hdl/slab_slot_allocator_top.sv
tb/slab_slot_allocator_top_test.sv
